// ----- hw/rtl/pksc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Phone key sort and count package
// Shared types, codes and the keypad table for the key sorter and counter.
// ----------------------------------------------------------------------------
package pksc_pkg;

    localparam int MAX_NUMBERS_DEF = 128;
    localparam int KEY_LEN_DEF     = 128;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_PULL = 2'd2;

    localparam logic [7:0] ASCII_0      = 8'h30;
    localparam logic [7:0] ASCII_9      = 8'h39;
    localparam logic [7:0] ASCII_A      = 8'h41;
    localparam logic [7:0] ASCII_Z      = 8'h5A;
    localparam logic [7:0] ASCII_HYPHEN = 8'h2D;

    localparam logic [3:0] HYPHEN_CODE = 4'd0;
    localparam logic [7:0] TALLY_MAX   = 8'd255;

    // Stored codes of the letters A to Z: keypad digit plus one.
    localparam logic [3:0] KEYPAD [26] = '{
        4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5,
        4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8,
        4'd9, 4'd9, 4'd9, 4'd10, 4'd10, 4'd10, 4'd10
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        logic       valid_res;
        logic [5:0] out_char;
        logic       is_count;
        logic [7:0] count;
        logic       all_done;
        logic       overflow;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHAR,
        S_CHAR2,
        S_SEARCH,
        S_ROW,
        S_CMP,
        S_CHK,
        S_TALLY_RD,
        S_TALLY_WR,
        S_NEW,
        S_COPY,
        S_COPY_WR,
        S_SHIFT,
        S_SHIFT_WR,
        S_PULL,
        S_PULL_ROW,
        S_PULL_SEL,
        S_PULL_CHAR,
        S_PUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_HYPHEN,
        OP_CHAR,
        OP_SEARCH_RD,
        OP_ROW_RD,
        OP_CMP_RD,
        OP_IDX_INC,
        OP_POS_INC,
        OP_TALLY_RD,
        OP_TALLY_WR,
        OP_DROP,
        OP_NEW,
        OP_COPY_RD,
        OP_COPY_WR,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_PLACE,
        OP_PULL_EMPTY,
        OP_PULL_RD,
        OP_PULL_ROW,
        OP_PULL_COUNT,
        OP_PULL_CHR_RD,
        OP_PULL_CHAR,
        OP_PUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic hyph;
        logic at_end;
        logic cmp_done;
        logic len_lt;
        logic len_eq;
        logic chr_lt;
        logic chr_eq;
        logic full;
        logic copy_done;
        logic shift_done;
        logic emit_empty;
        logic pos_in_key;
        logic out_free;
    } status_t;

    // Returns a keep flag and the stored code of one raw character.
    function automatic logic [4:0] char_code(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= ASCII_0 && c <= ASCII_9) begin
            r = {1'b1, 4'(c - ASCII_0 + 8'd1)};
        end else if (c >= ASCII_A && c <= ASCII_Z) begin
            r = {1'b1, KEYPAD[5'(c - ASCII_A)]};
        end
        return r;
    endfunction

    function automatic logic [5:0] code_to_ascii(input logic [3:0] code);
        logic [7:0] a;
        a = ASCII_0 + 8'(code) - 8'd1;
        if (code == HYPHEN_CODE) begin
            a = ASCII_HYPHEN;
        end
        return a[5:0];
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/phone_key_sort_and_count.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Phone key sort and count
// Normalizes phone numbers to keypad keys, keeps them sorted and counted.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the block stalls its input until the item
// is finished. A pull prepares its result and then waits for the result
// register to be free. An end of number walks the sorted key table through
// single-port memories: it compares the keys in order over their common
// leading characters, then for a new key stores its characters and moves the
// later keys up in the order table. No clearing pass is needed after reset.
module phone_key_sort_and_count #(
    parameter int MAX_NUMBERS = pksc_pkg::MAX_NUMBERS_DEF,
    parameter int KEY_LEN     = pksc_pkg::KEY_LEN_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire pksc_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output pksc_pkg::result_t      result
);
    import pksc_pkg::*;

    cmd_t    cmd;
    status_t status;

    pksc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .kind       (item.kind),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    pksc_datapath #(
        .MAX_NUMBERS (MAX_NUMBERS),
        .KEY_LEN     (KEY_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ch           (item.ch),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/pksc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Phone key sort and count controller
// Sequences character appends, the sorted search and insert, and pulls.
// ----------------------------------------------------------------------------
module pksc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic [1:0]        kind,
    input  wire pksc_pkg::status_t status,
    output logic                   item_stall,
    output pksc_pkg::cmd_t         cmd
);
    import pksc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op = OP_LATCH;
                    case (kind)
                        KIND_CHAR: state_next = S_CHAR;
                        KIND_END:  state_next = S_SEARCH;
                        KIND_PULL: state_next = S_PULL;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CHAR:
            begin
                if (status.hyph)
                begin
                    cmd.op     = OP_HYPHEN;
                    state_next = S_CHAR2;
                end
                else
                begin
                    cmd.op     = OP_CHAR;
                    state_next = S_IDLE;
                end
            end
            S_CHAR2:
            begin
                cmd.op     = OP_CHAR;
                state_next = S_IDLE;
            end
            S_SEARCH:
            begin
                if (status.at_end)
                begin
                    state_next = S_NEW;
                end
                else
                begin
                    cmd.op     = OP_SEARCH_RD;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.op     = OP_ROW_RD;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (status.cmp_done)
                begin
                    if (status.len_eq)
                    begin
                        state_next = S_TALLY_RD;
                    end
                    else if (status.len_lt)
                    begin
                        state_next = S_NEW;
                    end
                    else
                    begin
                        cmd.op     = OP_POS_INC;
                        state_next = S_SEARCH;
                    end
                end
                else
                begin
                    cmd.op     = OP_CMP_RD;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (status.chr_eq)
                begin
                    cmd.op     = OP_IDX_INC;
                    state_next = S_CMP;
                end
                else if (status.chr_lt)
                begin
                    state_next = S_NEW;
                end
                else
                begin
                    cmd.op     = OP_POS_INC;
                    state_next = S_SEARCH;
                end
            end
            S_TALLY_RD:
            begin
                cmd.op     = OP_TALLY_RD;
                state_next = S_TALLY_WR;
            end
            S_TALLY_WR:
            begin
                cmd.op     = OP_TALLY_WR;
                state_next = S_IDLE;
            end
            S_NEW:
            begin
                if (status.full)
                begin
                    cmd.op     = OP_DROP;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_NEW;
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                if (status.copy_done)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    cmd.op     = OP_COPY_RD;
                    state_next = S_COPY_WR;
                end
            end
            S_COPY_WR:
            begin
                cmd.op     = OP_COPY_WR;
                state_next = S_COPY;
            end
            S_SHIFT:
            begin
                if (status.shift_done)
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.op     = OP_SHIFT_WR;
                state_next = S_SHIFT;
            end
            S_PULL:
            begin
                if (status.emit_empty)
                begin
                    cmd.op     = OP_PULL_EMPTY;
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.op     = OP_PULL_RD;
                    state_next = S_PULL_ROW;
                end
            end
            S_PULL_ROW:
            begin
                cmd.op     = OP_PULL_ROW;
                state_next = S_PULL_SEL;
            end
            S_PULL_SEL:
            begin
                if (status.pos_in_key)
                begin
                    cmd.op     = OP_PULL_CHR_RD;
                    state_next = S_PULL_CHAR;
                end
                else
                begin
                    cmd.op     = OP_PULL_COUNT;
                    state_next = S_PUT;
                end
            end
            S_PULL_CHAR:
            begin
                cmd.op     = OP_PULL_CHAR;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_PUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pksc_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Phone key sort and count datapath
// Key buffer, key rows, sorted order table, lengths, counts and result stage.
// ----------------------------------------------------------------------------
module pksc_datapath #(
    parameter int MAX_NUMBERS = pksc_pkg::MAX_NUMBERS_DEF,
    parameter int KEY_LEN     = pksc_pkg::KEY_LEN_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        ch,
    input  wire pksc_pkg::cmd_t    cmd,
    output pksc_pkg::status_t      status,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output pksc_pkg::result_t      result
);
    import pksc_pkg::*;

    localparam int NW = $clog2(MAX_NUMBERS + 1);
    localparam int RW = $clog2(MAX_NUMBERS);
    localparam int LW = $clog2(KEY_LEN + 1);
    localparam int PW = $clog2(KEY_LEN);

    logic [NW-1:0] entries_reg, entries_next;
    logic [LW-1:0] blen_reg, blen_next;
    logic [NW-1:0] emit_entry_reg, emit_entry_next;
    logic [LW-1:0] emit_pos_reg, emit_pos_next;
    logic          ovf_reg, ovf_next;
    logic [NW-1:0] pos_reg, pos_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [NW-1:0] sh_reg, sh_next;
    logic [RW-1:0] row_reg, row_next;
    logic [7:0]    ch_reg, ch_next;
    result_t       res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic [3:0]    bbuf_mem  [KEY_LEN];
    logic [3:0]    kstore_mem[MAX_NUMBERS * (2 ** PW)];
    logic [RW-1:0] order_mem [MAX_NUMBERS];
    logic [LW-1:0] len_mem   [MAX_NUMBERS];
    logic [7:0]    tally_mem [MAX_NUMBERS];

    logic [3:0]    bb_rd_reg;
    logic [3:0]    ks_rd_reg;
    logic [RW-1:0] order_rd_reg;
    logic [LW-1:0] len_rd_reg;
    logic [7:0]    tally_rd_reg;

    logic          bb_we, bb_re;
    logic [PW-1:0] bb_waddr, bb_raddr;
    logic [3:0]    bb_wdata;
    logic          ks_we, ks_re;
    logic [RW+PW-1:0] ks_waddr, ks_raddr;
    logic          or_we, or_re;
    logic [RW-1:0] or_waddr, or_raddr, or_wdata;
    logic          len_we, len_re;
    logic          ta_we, ta_re;
    logic [RW-1:0] ta_waddr, ta_raddr;
    logic [7:0]    ta_wdata;

    logic [RW-1:0] new_row;
    logic [LW-1:0] min_len;
    logic [4:0]    cc;
    logic          room;
    logic [NW:0]   emit_plus;

    assign new_row   = entries_reg[RW-1:0];
    assign min_len   = (blen_reg < len_rd_reg) ? blen_reg : len_rd_reg;
    assign cc        = char_code(ch_reg);
    assign room      = (blen_reg < LW'(KEY_LEN));
    assign emit_plus = {1'b0, emit_entry_reg} + {{NW{1'b0}}, 1'b1};

    always_comb
    begin
        status.hyph       = (blen_reg == LW'(4));
        status.at_end     = (pos_reg == entries_reg);
        status.cmp_done   = (idx_reg == min_len);
        status.len_lt     = (blen_reg < len_rd_reg);
        status.len_eq     = (blen_reg == len_rd_reg);
        status.chr_lt     = (bb_rd_reg < ks_rd_reg);
        status.chr_eq     = (bb_rd_reg == ks_rd_reg);
        status.full       = (entries_reg == NW'(MAX_NUMBERS));
        status.copy_done  = (idx_reg == blen_reg);
        status.shift_done = (sh_reg == pos_reg);
        status.emit_empty = (emit_entry_reg >= entries_reg);
        status.pos_in_key = (emit_pos_reg < len_rd_reg);
        status.out_free   = !out_valid_reg || !result_stall;
    end

    always_comb
    begin
        entries_next    = entries_reg;
        blen_next       = blen_reg;
        emit_entry_next = emit_entry_reg;
        emit_pos_next   = emit_pos_reg;
        ovf_next        = ovf_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        sh_next         = sh_reg;
        row_next        = row_reg;
        ch_next         = ch_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        bb_we    = 1'b0;
        bb_re    = 1'b0;
        bb_waddr = blen_reg[PW-1:0];
        bb_raddr = idx_reg[PW-1:0];
        bb_wdata = cc[3:0];
        ks_we    = 1'b0;
        ks_re    = 1'b0;
        ks_waddr = {new_row, idx_reg[PW-1:0]};
        ks_raddr = {row_reg, idx_reg[PW-1:0]};
        or_we    = 1'b0;
        or_re    = 1'b0;
        or_waddr = pos_reg[RW-1:0];
        or_raddr = pos_reg[RW-1:0];
        or_wdata = new_row;
        len_we   = 1'b0;
        len_re   = 1'b0;
        ta_we    = 1'b0;
        ta_re    = 1'b0;
        ta_waddr = new_row;
        ta_raddr = row_reg;
        ta_wdata = 8'd1;

        case (cmd.op)
            OP_LATCH:
            begin
                ch_next  = ch;
                pos_next = '0;
            end
            OP_HYPHEN:
            begin
                if (room)
                begin
                    bb_we     = 1'b1;
                    bb_wdata  = HYPHEN_CODE;
                    blen_next = blen_reg + LW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            OP_CHAR:
            begin
                if (cc[4])
                begin
                    if (room)
                    begin
                        bb_we     = 1'b1;
                        blen_next = blen_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            OP_SEARCH_RD:
            begin
                or_re = 1'b1;
            end
            OP_ROW_RD:
            begin
                row_next = order_rd_reg;
                idx_next = '0;
                len_re   = 1'b1;
            end
            OP_CMP_RD:
            begin
                bb_re = 1'b1;
                ks_re = 1'b1;
            end
            OP_IDX_INC:
            begin
                idx_next = idx_reg + LW'(1);
            end
            OP_POS_INC:
            begin
                pos_next = pos_reg + NW'(1);
            end
            OP_TALLY_RD:
            begin
                ta_re = 1'b1;
            end
            OP_TALLY_WR:
            begin
                ta_we     = 1'b1;
                ta_waddr  = row_reg;
                ta_wdata  = (tally_rd_reg == TALLY_MAX) ? TALLY_MAX
                                                        : tally_rd_reg + 8'd1;
                blen_next = '0;
            end
            OP_DROP:
            begin
                ovf_next  = 1'b1;
                blen_next = '0;
            end
            OP_NEW:
            begin
                len_we   = 1'b1;
                ta_we    = 1'b1;
                idx_next = '0;
                sh_next  = entries_reg;
            end
            OP_COPY_RD:
            begin
                bb_re = 1'b1;
            end
            OP_COPY_WR:
            begin
                ks_we    = 1'b1;
                idx_next = idx_reg + LW'(1);
            end
            OP_SHIFT_RD:
            begin
                or_re    = 1'b1;
                or_raddr = RW'(sh_reg - NW'(1));
            end
            OP_SHIFT_WR:
            begin
                or_we    = 1'b1;
                or_waddr = sh_reg[RW-1:0];
                or_wdata = order_rd_reg;
                sh_next  = sh_reg - NW'(1);
            end
            OP_PLACE:
            begin
                or_we        = 1'b1;
                entries_next = entries_reg + NW'(1);
                blen_next    = '0;
            end
            OP_PULL_EMPTY:
            begin
                res_next           = '0;
                res_next.all_done  = 1'b1;
                res_next.overflow  = ovf_reg;
            end
            OP_PULL_RD:
            begin
                or_re    = 1'b1;
                or_raddr = emit_entry_reg[RW-1:0];
            end
            OP_PULL_ROW:
            begin
                row_next = order_rd_reg;
                len_re   = 1'b1;
                ta_re    = 1'b1;
                ta_raddr = order_rd_reg;
            end
            OP_PULL_COUNT:
            begin
                res_next           = '0;
                res_next.valid_res = 1'b1;
                res_next.is_count  = 1'b1;
                res_next.count     = tally_rd_reg;
                res_next.all_done  = (emit_plus >= {1'b0, entries_reg});
                res_next.overflow  = ovf_reg;
                emit_entry_next    = emit_plus[NW-1:0];
                emit_pos_next      = '0;
            end
            OP_PULL_CHR_RD:
            begin
                ks_re    = 1'b1;
                ks_raddr = {row_reg, emit_pos_reg[PW-1:0]};
            end
            OP_PULL_CHAR:
            begin
                res_next           = '0;
                res_next.valid_res = 1'b1;
                res_next.out_char  = code_to_ascii(ks_rd_reg);
                res_next.overflow  = ovf_reg;
                emit_pos_next      = emit_pos_reg + LW'(1);
            end
            OP_PUT:
            begin
                out_next       = res_reg;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg    <= '0;
            blen_reg       <= '0;
            emit_entry_reg <= '0;
            emit_pos_reg   <= '0;
            ovf_reg        <= 1'b0;
            pos_reg        <= '0;
            idx_reg        <= '0;
            sh_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            entries_reg    <= entries_next;
            blen_reg       <= blen_next;
            emit_entry_reg <= emit_entry_next;
            emit_pos_reg   <= emit_pos_next;
            ovf_reg        <= ovf_next;
            pos_reg        <= pos_next;
            idx_reg        <= idx_next;
            sh_reg         <= sh_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        ch_reg  <= ch_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (bb_we)
        begin
            bbuf_mem[bb_waddr] <= bb_wdata;
        end
        if (bb_re)
        begin
            bb_rd_reg <= bbuf_mem[bb_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ks_we)
        begin
            kstore_mem[ks_waddr] <= bb_rd_reg;
        end
        if (ks_re)
        begin
            ks_rd_reg <= kstore_mem[ks_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (or_we)
        begin
            order_mem[or_waddr] <= or_wdata;
        end
        if (or_re)
        begin
            order_rd_reg <= order_mem[or_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[new_row] <= blen_reg;
        end
        if (len_re)
        begin
            len_rd_reg <= len_mem[order_rd_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ta_we)
        begin
            tally_mem[ta_waddr] <= ta_wdata;
        end
        if (ta_re)
        begin
            tally_rd_reg <= tally_mem[ta_raddr];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phone key sort and count testbench
// Drives characters, number ends and pulls through the valid/stall ports and
// checks every result against a behavioral copy of the sorted key table.
// ----------------------------------------------------------------------------
class key_table_board;
    byte unsigned rows[$][$];
    int unsigned  tallies[$];
    byte unsigned building[$];
    int unsigned  emit_row;
    int unsigned  emit_pos;
    bit           dropped;
    pksc_pkg::result_t pending[$];
    int unsigned  errors;

    function void put_code(byte unsigned code);
        if (building.size() < pksc_pkg::KEY_LEN_DEF)
        begin
            building.push_back(code);
        end
        else
        begin
            dropped = 1'b1;
        end
    endfunction

    function int order_against(int unsigned r);
        int unsigned n;
        n = building.size() < rows[r].size() ? building.size() : rows[r].size();
        for (int unsigned i = 0; i < n; i++)
        begin
            if (building[i] != rows[r][i])
            begin
                return building[i] < rows[r][i] ? -1 : 1;
            end
        end
        if (building.size() == rows[r].size())
        begin
            return 0;
        end
        return building.size() < rows[r].size() ? -1 : 1;
    endfunction

    function void close_number();
        int unsigned p;
        int c;
        p = 0;
        c = 1;
        while (p < rows.size())
        begin
            c = order_against(p);
            if (c <= 0)
            begin
                break;
            end
            p++;
        end
        if (p < rows.size() && c == 0)
        begin
            if (tallies[p] < 255)
            begin
                tallies[p]++;
            end
        end
        else if (rows.size() < pksc_pkg::MAX_NUMBERS_DEF)
        begin
            rows.insert(p, building);
            tallies.insert(p, 1);
        end
        else
        begin
            dropped = 1'b1;
        end
        building.delete();
    endfunction

    function void note_item(pksc_pkg::item_t it);
        pksc_pkg::result_t r;
        byte unsigned code;
        if (it.kind == pksc_pkg::KIND_CHAR)
        begin
            if (building.size() == 4)
            begin
                put_code(8'(pksc_pkg::HYPHEN_CODE));
            end
            if (it.ch >= pksc_pkg::ASCII_0 && it.ch <= pksc_pkg::ASCII_9)
            begin
                put_code(8'(it.ch - pksc_pkg::ASCII_0 + 8'd1));
            end
            else if (it.ch >= pksc_pkg::ASCII_A && it.ch <= pksc_pkg::ASCII_Z)
            begin
                case (it.ch)
                    "A", "B", "C": code = 3;
                    "D", "E", "F": code = 4;
                    "G", "H", "I": code = 5;
                    "J", "K", "L": code = 6;
                    "M", "N", "O": code = 7;
                    "P", "Q", "R", "S": code = 8;
                    "T", "U", "V": code = 9;
                    default: code = 10;
                endcase
                put_code(code);
            end
        end
        else if (it.kind == pksc_pkg::KIND_END)
        begin
            close_number();
        end
        else if (it.kind == pksc_pkg::KIND_PULL)
        begin
            r = '0;
            if (emit_row < rows.size())
            begin
                r.valid_res = 1'b1;
                if (emit_pos < rows[emit_row].size())
                begin
                    code = rows[emit_row][emit_pos];
                    r.out_char = code == pksc_pkg::HYPHEN_CODE
                                 ? 6'(pksc_pkg::ASCII_HYPHEN)
                                 : 6'(pksc_pkg::ASCII_0 + code - 8'd1);
                    emit_pos++;
                end
                else
                begin
                    r.is_count = 1'b1;
                    r.count = 8'(tallies[emit_row]);
                    emit_row++;
                    emit_pos = 0;
                end
            end
            r.all_done = emit_row >= rows.size();
            r.overflow = dropped;
            pending.push_back(r);
        end
    endfunction

    function void check_result(pksc_pkg::result_t got);
        pksc_pkg::result_t want;
        if (pending.size() == 0)
        begin
            $error("unexpected result %h", got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.valid_res !== want.valid_res)
        begin
            $error("valid_res expected %0d actual %0d", want.valid_res, got.valid_res);
            errors++;
        end
        if (got.out_char !== want.out_char)
        begin
            $error("out_char expected %0d actual %0d", want.out_char, got.out_char);
            errors++;
        end
        if (got.is_count !== want.is_count)
        begin
            $error("is_count expected %0d actual %0d", want.is_count, got.is_count);
            errors++;
        end
        if (got.count !== want.count)
        begin
            $error("count expected %0d actual %0d", want.count, got.count);
            errors++;
        end
        if (got.all_done !== want.all_done)
        begin
            $error("all_done expected %0d actual %0d", want.all_done, got.all_done);
            errors++;
        end
        if (got.overflow !== want.overflow)
        begin
            $error("overflow expected %0d actual %0d", want.overflow, got.overflow);
            errors++;
        end
    endfunction
endclass

module tb;
    import pksc_pkg::*;

    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b1;
    result_t result;

    key_table_board board = new();
    bit      long_hold = 1'b0;
    longint  cycles = 0;
    int      numbers_ended = 0;

    phone_key_sort_and_count uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always #1 clk = ~clk;

    task automatic send(logic [1:0] kind, logic [7:0] ch);
        int unsigned gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
        begin
            gap = 0;
        end
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap)
            begin
                @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        item <= '{kind: kind, ch: ch};
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        board.note_item('{kind: kind, ch: ch});
        if (kind == KIND_END)
        begin
            numbers_ended++;
        end
    endtask

    task automatic send_number(int unsigned len, bit noisy);
        logic [7:0] c;
        for (int unsigned i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 3) == 0)
            begin
                c = 8'($urandom_range(0, 255));
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                c = 8'($urandom_range(ASCII_A, ASCII_Z));
            end
            else
            begin
                c = 8'($urandom_range(ASCII_0, ASCII_0 + 2));
            end
            send(KIND_CHAR, c);
        end
        send(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            board.check_result(result);
        end
    end

    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        while (1)
        begin
            @(posedge clk);
            if (long_hold)
            begin
                result_stall <= 1'b1;
                repeat (3000)
                begin
                    @(posedge clk);
                end
                long_hold = 1'b0;
            end
            hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold - 1)
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("phone_key_sort_and_count regression: fail");
            $finish;
        end
    end

    initial
    begin
        string s;
        repeat (12)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        send(KIND_PULL, 8'h00);
        send(KIND_END, 8'h00);
        s = "0123456789";
        for (int i = 0; i < s.len(); i++)
        begin
            send(KIND_CHAR, s[i]);
        end
        send(KIND_CHAR, 8'hFF);
        send(KIND_CHAR, "a");
        send(KIND_END, 8'h00);
        s = "AZPSWY";
        for (int i = 0; i < s.len(); i++)
        begin
            send(KIND_CHAR, s[i]);
        end
        send(KIND_SPARE, 8'hFF);
        send(KIND_END, 8'h00);
        for (int i = 0; i < 5; i++)
        begin
            send(KIND_PULL, 8'h00);
        end
        for (int i = 0; i < 140; i++)
        begin
            send(KIND_CHAR, 8'h39);
        end
        send(KIND_END, 8'h00);

        long_hold = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            send(KIND_PULL, 8'h00);
        end

        while (numbers_ended < 330)
        begin
            case ($urandom_range(0, 9))
                0: send(KIND_PULL, 8'($urandom_range(0, 255)));
                1: send(KIND_CHAR, 8'($urandom_range(0, 255)));
                2: send(KIND_SPARE, 8'($urandom_range(0, 255)));
                default: send_number($urandom_range(0, 5), $urandom_range(0, 1));
            endcase
        end
        for (int i = 0; i < 140; i++)
        begin
            send(KIND_END, 8'h00);
        end
        for (int i = 0; i < 260; i++)
        begin
            send(KIND_PULL, 8'($urandom_range(0, 255)));
        end
        item_valid <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50)
        begin
            @(posedge clk);
        end
        if (board.errors == 0)
        begin
            $display("phone_key_sort_and_count regression: pass");
        end
        else
        begin
            $display("phone_key_sort_and_count regression: fail");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/pksc_pkg.sv
hw/rtl/pksc_ctrl.sv
hw/rtl/pksc_datapath.sv
hw/rtl/phone_key_sort_and_count.sv
tb/sv/tb.sv
